// ===== sv/transform_matrix_accumulator_defines.svh =====
// Assertion macros used by the transform matrix accumulator top level.
`ifndef TRANSFORM_MATRIX_ACCUMULATOR_DEFINES_SVH
`define TRANSFORM_MATRIX_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TMA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tma assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tma assertion failed");

`endif

// ===== sv/tma_pkg.sv =====
// Shared types, constants and helpers of the transform matrix accumulator.
package tma_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int ROWS      = 4;
    localparam int OP_BITS   = 3;
    localparam int IDX_BITS  = 4;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int SH_BITS   = PROD_BITS - FRAC_BITS;
    localparam int ACC_BITS  = SH_BITS + 2;
    localparam int COL_BITS  = ROWS * WORD_BITS;

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic [OP_BITS-1:0]          t_opcode;
    typedef logic [IDX_BITS-1:0]         t_index;

    localparam t_opcode OP_IDENTITY  = 3'd0;
    localparam t_opcode OP_WRITE     = 3'd1;
    localparam t_opcode OP_COPY      = 3'd2;
    localparam t_opcode OP_MULTIPLY  = 3'd3;
    localparam t_opcode OP_TRANSLATE = 3'd4;
    localparam t_opcode OP_SCALE     = 3'd5;

    localparam t_word UNIT_VALUE = t_word'(64'd1 << FRAC_BITS);
    localparam t_word WORD_MAX   = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam t_word WORD_MIN   = {1'b1, {(WORD_BITS-1){1'b0}}};

    // Control of one multiply-accumulate lane.
    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic first;
    } t_mac_ctrl;

    function automatic t_word identity_elem(input logic [1:0] row, input logic [1:0] col);
        return (row == col) ? UNIT_VALUE : '0;
    endfunction

endpackage

// ===== sv/tma_in_if.sv =====
// Input channel of the transform matrix accumulator: one operation per transfer.
interface tma_in_if;
    import tma_pkg::*;

    logic    valid;
    logic    ready;
    t_opcode opcode;
    t_index  elem_index;
    t_word   elem_value;
    t_word   coord_x;
    t_word   coord_y;
    t_word   coord_z;

    modport source (
        output valid, opcode, elem_index, elem_value, coord_x, coord_y, coord_z,
        input  ready
    );

    modport sink (
        input  valid, opcode, elem_index, elem_value, coord_x, coord_y, coord_z,
        output ready
    );
endinterface

// ===== sv/tma_out_if.sv =====
// Output channel of the transform matrix accumulator: one readback per transfer.
interface tma_out_if;
    import tma_pkg::*;

    logic  valid;
    logic  ready;
    t_word read_value;
    logic  overflow;

    modport source (
        output valid, read_value, overflow,
        input  ready
    );

    modport sink (
        input  valid, read_value, overflow,
        output ready
    );
endinterface

// ===== sv/transform_matrix_accumulator.sv =====
// Top level of the transform matrix accumulator: sequencer, matrix stores and MAC lanes.
//
// Keeps a current 4x4 column-major Q16.16 transform matrix and an operand matrix and
// applies one operation per input transfer: load identity, write one operand element,
// copy the operand into the current matrix, or post-multiply the current matrix by the
// operand, by a translation or by a scale. Every transfer returns one result: the current
// element at elem_index after the operation, with overflow set when any stored sum
// saturated. The current matrix lives in a RAM of two banks of four 128-bit columns; a
// post-multiply reads the old bank one column per cycle while four MAC lanes (one per
// row) build each new column and write it into the other bank, which becomes current
// once the pipeline has drained, so the old matrix is used throughout. Copy runs through
// the same path with the old matrix taken as identity. Per-column valid bits stand for
// the identity reset and for load identity, and per-element valid bits for the zeroed
// operand, so there is no clearing pass. Flow: load identity, operand write and unused
// opcodes pass from the transfer through S_READ into the result register (S_RESULT);
// copy, multiply, translate and scale pass from the transfer through issue of every
// factor element in turn (one current column and one operand element read per cycle),
// a drain of the three-stage MAC pipeline (S_DRAIN) and then the same readback.
// A new input transfer is taken the cycle after the result is registered, even while
// that result still waits to be taken.
`include "transform_matrix_accumulator_defines.svh"

module transform_matrix_accumulator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tma_in_if.sink    i_in,
    tma_out_if.source o_out
);
    import tma_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_RUN    = 5'b00010,
        S_DRAIN  = 5'b00100,
        S_READ   = 5'b01000,
        S_RESULT = 5'b10000
    } t_state;

    typedef struct packed {
        logic       vld;
        logic       first;
        logic       last;
        logic [1:0] col;
        logic [1:0] k;
    } t_tag;

    t_state r_state, n_state;

    logic          r_bank;
    logic [3:0]    r_step;
    logic [7:0]    r_cur_vld;
    logic [15:0]   r_opd_vld;
    logic          r_cur_rvld;
    logic          r_opd_rvld;
    t_opcode       r_op;
    t_index        r_idx;
    t_word         r_cx, r_cy, r_cz;
    logic          r_ovf;
    t_word         r_gen_t;
    t_word         n_gen_t;
    t_tag          r_tag_a, r_tag_b, r_tag_c, n_tag_a;

    logic          r_out_vld;
    t_word         r_out_value;
    logic          r_out_ovf;

    logic          accept;
    logic          issue;
    logic          pipe_empty;
    logic          out_load;
    logic          cur_re, cur_we;
    logic [2:0]    cur_raddr, cur_waddr;
    logic [COL_BITS-1:0] cur_rdata, cur_wdata;
    logic          opd_we;
    t_word         opd_rdata;
    t_word         coord_k;
    t_word         lane_a [ROWS];
    t_word         lane_b;
    t_word         lane_word [ROWS];
    logic [ROWS-1:0] lane_sat;
    t_mac_ctrl     mac_ctrl;
    t_word         readback;

    assign accept     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign issue      = (r_state == S_RUN);
    assign pipe_empty = !r_tag_a.vld && !r_tag_b.vld && !r_tag_c.vld;
    assign out_load   = (r_state == S_RESULT) && (!r_out_vld || o_out.ready);

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in.opcode inside {OP_COPY, OP_MULTIPLY, OP_TRANSLATE, OP_SCALE}) begin
                        n_state = S_RUN;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_RUN: begin
                if (r_step == 4'hF) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (pipe_empty) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_bank    <= 1'b0;
            r_step    <= '0;
            r_cur_vld <= '0;
            r_opd_vld <= '0;
            r_ovf     <= 1'b0;
            r_tag_a   <= '0;
            r_tag_b   <= '0;
            r_tag_c   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tag_a <= n_tag_a;
            r_tag_b <= r_tag_a;
            r_tag_c <= r_tag_b;

            if (accept) begin
                r_step <= '0;
                r_ovf  <= 1'b0;
            end else if (issue) begin
                r_step <= r_step + 4'd1;
            end

            // Load identity: mark the columns of the current bank as identity.
            if (accept && i_in.opcode == OP_IDENTITY) begin
                for (int j = 0; j < ROWS; j++) begin
                    r_cur_vld[{r_bank, 2'(j)}] <= 1'b0;
                end
            end
            if (cur_we) begin
                r_cur_vld[cur_waddr] <= 1'b1;
                if (|lane_sat) begin
                    r_ovf <= 1'b1;
                end
            end
            if (opd_we) begin
                r_opd_vld[i_in.elem_index] <= 1'b1;
            end

            // Flip to the freshly written bank once the last column has landed.
            if (r_state == S_DRAIN && pipe_empty) begin
                r_bank <= ~r_bank;
            end

            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Hold the fields of the transfer for the whole operation.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_in.opcode;
            r_idx <= i_in.elem_index;
            r_cx  <= i_in.coord_x;
            r_cy  <= i_in.coord_y;
            r_cz  <= i_in.coord_z;
        end
        if (cur_re) begin
            r_cur_rvld <= r_cur_vld[cur_raddr];
        end
        if (issue) begin
            r_opd_rvld <= r_opd_vld[r_step];
            r_gen_t    <= n_gen_t;
        end
        if (out_load) begin
            r_out_value <= readback;
            r_out_ovf   <= r_ovf;
        end
    end

    // Issue: step = column of the factor * 4 + k.
    always_comb begin
        n_tag_a.vld   = issue;
        n_tag_a.first = (r_step[1:0] == 2'd0);
        n_tag_a.last  = (r_step[1:0] == 2'd3);
        n_tag_a.col   = r_step[3:2];
        n_tag_a.k     = r_step[1:0];
    end

    // Build the translation or scale factor element at (column, k).
    always_comb begin
        case (r_step[1:0])
            2'd0:    coord_k = r_cx;
            2'd1:    coord_k = r_cy;
            2'd2:    coord_k = r_cz;
            default: coord_k = UNIT_VALUE;
        endcase
        case (r_op)
            OP_TRANSLATE: begin
                if (r_step[3:2] == 2'd3) begin
                    n_gen_t = coord_k;
                end else begin
                    n_gen_t = identity_elem(r_step[1:0], r_step[3:2]);
                end
            end
            OP_SCALE: begin
                n_gen_t = (r_step[1:0] == r_step[3:2]) ? coord_k : '0;
            end
            default: begin
                n_gen_t = '0;
            end
        endcase
    end

    assign cur_re    = issue || (r_state == S_READ);
    assign cur_raddr = issue ? {r_bank, r_step[1:0]} : {r_bank, r_idx[3:2]};
    assign cur_we    = r_tag_c.vld && r_tag_c.last;
    assign cur_waddr = {~r_bank, r_tag_c.col};
    assign opd_we    = accept && (i_in.opcode == OP_WRITE);

    tma_ram #(
        .DEPTH (8),
        .WIDTH (COL_BITS)
    ) u_cur_ram (
        .i_clk   (i_clk),
        .i_we    (cur_we),
        .i_waddr (cur_waddr),
        .i_wdata (cur_wdata),
        .i_re    (cur_re),
        .i_raddr (cur_raddr),
        .o_rdata (cur_rdata)
    );

    tma_ram #(
        .DEPTH (16),
        .WIDTH (WORD_BITS)
    ) u_opd_ram (
        .i_clk   (i_clk),
        .i_we    (opd_we),
        .i_waddr (i_in.elem_index),
        .i_wdata (i_in.elem_value),
        .i_re    (issue),
        .i_raddr (r_step),
        .o_rdata (opd_rdata)
    );

    // Lane operands: old column k row r, and the factor element (column, k).
    always_comb begin
        for (int r = 0; r < ROWS; r++) begin
            if (r_op == OP_COPY || !r_cur_rvld) begin
                lane_a[r] = identity_elem(2'(r), r_tag_a.k);
            end else begin
                lane_a[r] = cur_rdata[r*WORD_BITS +: WORD_BITS];
            end
        end
        if (r_op == OP_TRANSLATE || r_op == OP_SCALE) begin
            lane_b = r_gen_t;
        end else begin
            lane_b = r_opd_rvld ? opd_rdata : '0;
        end
    end

    assign mac_ctrl.mul_en = r_tag_a.vld;
    assign mac_ctrl.acc_en = r_tag_b.vld;
    assign mac_ctrl.first  = r_tag_b.first;

    for (genvar g = 0; g < ROWS; g++) begin : g_lane
        tma_mac_lane u_lane (
            .i_clk  (i_clk),
            .i_ctrl (mac_ctrl),
            .i_a    (lane_a[g]),
            .i_b    (lane_b),
            .o_word (lane_word[g]),
            .o_sat  (lane_sat[g])
        );
    end

    always_comb begin
        for (int r = 0; r < ROWS; r++) begin
            cur_wdata[r*WORD_BITS +: WORD_BITS] = lane_word[r];
        end
    end

    // Readback of the current element; an unwritten column reads as identity.
    always_comb begin
        if (r_cur_rvld) begin
            readback = cur_rdata[r_idx[1:0]*WORD_BITS +: WORD_BITS];
        end else begin
            readback = identity_elem(r_idx[1:0], r_idx[3:2]);
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.read_value = r_out_value;
    assign o_out.overflow   = r_out_ovf;

    // A new column never lands in the bank that is being read.
    `TMA_ASSERT_IMPL(a_write_other_bank, i_clk, i_rst_n, cur_we, cur_waddr[2] != r_bank)
    // Readback waits until every column of a post-multiply has been written.
    `TMA_ASSERT_IMPL(a_read_after_drain, i_clk, i_rst_n, r_state == S_READ, pipe_empty)
    // A matrix operation starts issuing in the cycle after its transfer.
    `TMA_ASSERT_NEXT(a_run_after_accept, i_clk, i_rst_n,
        accept && (i_in.opcode == OP_COPY || i_in.opcode == OP_MULTIPLY ||
        i_in.opcode == OP_TRANSLATE || i_in.opcode == OP_SCALE), r_state == S_RUN && r_step == 4'd0)
endmodule

// ===== sv/tma_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module tma_ram #(
    parameter int  DEPTH     = 16,
    parameter int  WIDTH     = 32,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/tma_mac_lane.sv =====
// One multiply-accumulate lane: registered product, shifted sum, saturation to a word.
module tma_mac_lane (
    input  logic              i_clk,
    input  tma_pkg::t_mac_ctrl i_ctrl,
    input  tma_pkg::t_word    i_a,
    input  tma_pkg::t_word    i_b,
    output tma_pkg::t_word    o_word,
    output logic              o_sat
);
    import tma_pkg::*;

    logic signed [PROD_BITS-1:0] r_prod;
    logic signed [SH_BITS-1:0]   prod_sh;
    logic signed [ACC_BITS-1:0]  r_acc;
    logic signed [ACC_BITS-1:0]  n_acc;
    logic [ACC_BITS-WORD_BITS:0] upper;
    logic                        fits;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= PROD_BITS'(i_a) * PROD_BITS'(i_b);
        end
        if (i_ctrl.acc_en) begin
            r_acc <= n_acc;
        end
    end

    // Drop the fraction bits, rounding toward minus infinity.
    assign prod_sh = SH_BITS'(r_prod >>> FRAC_BITS);

    always_comb begin
        if (i_ctrl.first) begin
            n_acc = ACC_BITS'(prod_sh);
        end else begin
            n_acc = r_acc + ACC_BITS'(prod_sh);
        end
    end

    assign upper  = r_acc[ACC_BITS-1:WORD_BITS-1];
    assign fits   = (&upper) | ~(|upper);
    assign o_sat  = ~fits;
    assign o_word = fits ? r_acc[WORD_BITS-1:0] : (r_acc[ACC_BITS-1] ? WORD_MIN : WORD_MAX);
endmodule

// ===== tb/sv/tma_readback_checker.sv =====
// Readback checker for the transform matrix accumulator: predicts and compares every result.
module tma_readback_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    tma_in_if    i_in,
    tma_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import tma_pkg::*;

    typedef t_word t_mat [16];

    typedef struct {
        t_word       read_value;
        logic        overflow;
        int unsigned seq;
    } t_readback;

    t_mat        cur_mat;
    t_mat        opnd_mat;
    t_readback   readback_q [$];
    int          fail_total;
    int unsigned seq_in;

    function automatic t_mat identity_mat();
        t_mat m;
        for (int e = 0; e < 16; e++) begin
            m[e] = (e % 5 == 0) ? UNIT_VALUE : '0;
        end
        return m;
    endfunction

    // Clamp a full-width sum to the word range, flagging any clamp.
    function automatic t_word sat_word(input longint sum, inout logic ov);
        if (sum > longint'(WORD_MAX)) begin
            ov = 1'b1;
            return WORD_MAX;
        end
        if (sum < longint'(WORD_MIN)) begin
            ov = 1'b1;
            return WORD_MIN;
        end
        return t_word'(sum);
    endfunction

    // current = current * xf, with the old current used for every element.
    function automatic void post_multiply(input t_mat xf, inout logic ov);
        t_mat   prior;
        longint acc;
        prior = cur_mat;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                acc = 0;
                for (int k = 0; k < 4; k++) begin
                    acc += (longint'(prior[k*4+r]) * longint'(xf[c*4+k])) >>> FRAC_BITS;
                end
                cur_mat[c*4+r] = sat_word(acc, ov);
            end
        end
    endfunction

    function automatic t_readback predict_readback(input t_opcode op, input t_index idx,
                                                   input t_word val, input t_word x,
                                                   input t_word y, input t_word z);
        t_readback rb;
        t_mat      xf;
        logic      ov;
        ov = 1'b0;
        case (op)
            OP_IDENTITY: cur_mat = identity_mat();
            OP_WRITE:    opnd_mat[idx] = val;
            OP_COPY:     cur_mat = opnd_mat;
            OP_MULTIPLY: post_multiply(opnd_mat, ov);
            OP_TRANSLATE: begin
                xf     = identity_mat();
                xf[12] = x;
                xf[13] = y;
                xf[14] = z;
                post_multiply(xf, ov);
            end
            OP_SCALE: begin
                xf     = '{default: '0};
                xf[0]  = x;
                xf[5]  = y;
                xf[10] = z;
                xf[15] = UNIT_VALUE;
                post_multiply(xf, ov);
            end
            default: ;
        endcase
        rb.read_value = cur_mat[idx];
        rb.overflow   = ov;
        rb.seq        = seq_in;
        return rb;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned seq,
                                   input t_word got, input t_word want);
        $display("mismatch on %0s of item %0d: got %h, expected %h", what, seq, got, want);
        fail_total++;
    endtask

    always @(posedge i_clk) begin
        t_readback want;
        if (!i_rst_n) begin
            cur_mat    = identity_mat();
            opnd_mat   = '{default: '0};
            fail_total = 0;
            seq_in     = 0;
            readback_q.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (readback_q.size() == 0) begin
                    report_mismatch("unexpected readback", seq_in, i_out.read_value, '0);
                end else begin
                    want = readback_q.pop_front();
                    if (i_out.read_value !== want.read_value)
                        report_mismatch("read_value", want.seq, i_out.read_value,
                                        want.read_value);
                    if (i_out.overflow !== want.overflow)
                        report_mismatch("overflow", want.seq, t_word'(i_out.overflow),
                                        t_word'(want.overflow));
                end
            end
            if (i_in.valid && i_in.ready) begin
                readback_q.push_back(predict_readback(i_in.opcode, i_in.elem_index,
                                                      i_in.elem_value, i_in.coord_x,
                                                      i_in.coord_y, i_in.coord_z));
                seq_in++;
            end
        end
        o_pending    <= readback_q.size();
        o_fail_count <= fail_total;
    end

endmodule

// ===== tb/sv/transform_matrix_accumulator_test.sv =====
// Testbench top of the transform matrix accumulator: stimulus, stalls and verdict.
module transform_matrix_accumulator_test;
    timeunit 1ns;
    timeprecision 1ps;
    import tma_pkg::*;

    // Opcodes the block leaves unused: they only read back.
    localparam t_opcode OP_SPARE_LO = 3'd6;
    localparam t_opcode OP_SPARE_HI = 3'd7;

    localparam int TOTAL_OPS        = 1400;
    localparam int CALM_FROM        = 1250;  // no idling from here on
    localparam int STALL_AT         = 600;   // item count at which the long hold starts
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES    = 40;    // longer than a whole multiply operation lasts
    localparam int CYCLE_LIMIT      = 500000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tma_in_if  in_ch ();
    tma_out_if out_ch ();

    int   fail_count;
    int   pending;
    int   ops_issued  = 0;
    int   tx_idle_pct = 10;
    int   rx_idle_pct = 10;
    logic calm_tail   = 1'b0;
    logic stall_req   = 1'b0;
    logic stall_done  = 1'b0;

    transform_matrix_accumulator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    tma_readback_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Random Q16.16 word: mostly modest magnitudes so products stay in range,
    // with full-range words, extremes and tiny raw values mixed in.
    function automatic t_word rand_fixed();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 45)
            return t_word'(int'($urandom_range(0, 262144)) - 131072);
        if (sel < 65)
            return t_word'(int'($urandom_range(0, 1048576)) - 524288);
        if (sel < 80)
            return t_word'($urandom);
        if (sel < 90) begin
            case ($urandom_range(0, 5))
                0:       return WORD_MAX;
                1:       return WORD_MIN;
                2:       return '0;
                3:       return UNIT_VALUE;
                4:       return -UNIT_VALUE;
                default: return -1;
            endcase
        end
        return t_word'(int'($urandom_range(0, 510)) - 255);
    endfunction

    // Drop valid for the hold length n, scrambling the payload meanwhile.
    task automatic hold_sender(input int n);
        @(negedge i_clk);
        in_ch.valid      <= 1'b0;
        in_ch.opcode     <= t_opcode'($urandom);
        in_ch.elem_index <= t_index'($urandom);
        in_ch.elem_value <= t_word'($urandom);
        in_ch.coord_x    <= t_word'($urandom);
        in_ch.coord_y    <= t_word'($urandom);
        in_ch.coord_z    <= t_word'($urandom);
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Offer one operation and hold it until the block takes the transfer.
    task automatic issue_op(input t_opcode op, input t_index idx, input t_word val,
                            input t_word x, input t_word y, input t_word z);
        if (!calm_tail && ($urandom_range(0, 99) < tx_idle_pct))
            hold_sender($urandom_range(1, 14));
        @(negedge i_clk);
        in_ch.valid      <= 1'b1;
        in_ch.opcode     <= op;
        in_ch.elem_index <= idx;
        in_ch.elem_value <= val;
        in_ch.coord_x    <= x;
        in_ch.coord_y    <= y;
        in_ch.coord_z    <= z;
        do @(posedge i_clk); while (!in_ch.ready);
        ops_issued++;
    endtask

    // Hold the sender until every expected readback has come back.
    task automatic drain_results();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Stimulus.
    initial begin
        int          base;
        int          n_writes;
        int          next_drain;
        int unsigned pick;
        t_opcode     apply_op;

        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.opcode     = OP_IDENTITY;
        in_ch.elem_index = '0;
        in_ch.elem_value = '0;
        in_ch.coord_x    = '0;
        in_ch.coord_y    = '0;
        in_ch.coord_z    = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: readback of the reset state through the unused opcodes.
        issue_op(OP_SPARE_LO, 4'd0, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN);
        issue_op(OP_SPARE_HI, 4'd1, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX);
        // Operand with extremes, a negative LSB (floors toward minus infinity) and a unit.
        issue_op(OP_WRITE, 4'd0, WORD_MAX, '0, '0, '0);
        issue_op(OP_WRITE, 4'd15, WORD_MIN, '0, '0, '0);
        issue_op(OP_WRITE, 4'd5, -1, '0, '0, '0);
        issue_op(OP_WRITE, 4'd10, UNIT_VALUE, '0, '0, '0);
        issue_op(OP_MULTIPLY, 4'd5, '0, '0, '0, '0);
        issue_op(OP_MULTIPLY, 4'd0, '0, '0, '0, '0);   // saturates both corners
        issue_op(OP_MULTIPLY, 4'd15, '0, '0, '0, '0);
        issue_op(OP_COPY, 4'd15, '0, '0, '0, '0);
        issue_op(OP_IDENTITY, 4'd5, '0, '0, '0, '0);
        // Translation at the extremes, then again to push the sums past the word range.
        issue_op(OP_TRANSLATE, 4'd12, '0, WORD_MAX, WORD_MIN, '0);
        issue_op(OP_TRANSLATE, 4'd13, '0, WORD_MAX, WORD_MIN, '0);
        issue_op(OP_IDENTITY, 4'd0, '0, '0, '0, '0);
        // Scale by the extremes twice: the second pass saturates.
        issue_op(OP_SCALE, 4'd0, '0, WORD_MIN, WORD_MAX, -1);
        issue_op(OP_SCALE, 4'd10, '0, WORD_MIN, WORD_MAX, -1);
        issue_op(OP_IDENTITY, 4'd10, '0, '0, '0, '0);
        issue_op(OP_SCALE, 4'd10, '0, '0, 1, -(UNIT_VALUE >>> 1));
        issue_op(OP_TRANSLATE, 4'd14, '0, 1, -1, UNIT_VALUE);
        issue_op(OP_WRITE, 4'd3, '0, '0, '0, '0);
        issue_op(OP_WRITE, 4'd12, 32'sh0001_8000, '0, '0, '0);
        issue_op(OP_MULTIPLY, 4'd12, '0, '0, '0, '0);
        issue_op(OP_COPY, 4'd3, '0, '0, '0, '0);
        issue_op(OP_IDENTITY, 4'd15, '0, '0, '0, '0);
        drain_results();

        // Random: mostly well-formed sequences (fill operand, then apply it),
        // transforms on a periodically reset matrix, and some raw noise.
        next_drain = 400;
        while (ops_issued < TOTAL_OPS) begin
            if (ops_issued >= next_drain) begin
                drain_results();
                next_drain += 400;
            end
            if (!stall_req && !stall_done && ops_issued >= STALL_AT &&
                ops_issued < STALL_AT + 40) begin
                stall_req  = 1'b1;
                stall_done = 1'b1;
            end
            if (ops_issued % 100 < 3)
                tx_idle_pct = $urandom_range(0, 3) * 8;
            calm_tail = (ops_issued >= CALM_FROM);

            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                base     = $urandom_range(0, 15);
                n_writes = ($urandom_range(0, 1) == 0) ? 16 : $urandom_range(1, 6);
                for (int e = 0; e < n_writes; e++) begin
                    issue_op(OP_WRITE,
                             (n_writes == 16) ? t_index'(e + base) : t_index'($urandom),
                             rand_fixed(), t_word'($urandom), t_word'($urandom),
                             t_word'($urandom));
                end
                apply_op = ($urandom_range(0, 3) == 0) ? OP_COPY : OP_MULTIPLY;
                issue_op(apply_op, t_index'($urandom), t_word'($urandom),
                         t_word'($urandom), t_word'($urandom), t_word'($urandom));
            end else if (pick < 60) begin
                issue_op(OP_TRANSLATE, t_index'($urandom), t_word'($urandom),
                         rand_fixed(), rand_fixed(), rand_fixed());
            end else if (pick < 80) begin
                issue_op(OP_SCALE, t_index'($urandom), t_word'($urandom),
                         rand_fixed(), rand_fixed(), rand_fixed());
            end else if (pick < 88) begin
                issue_op(OP_IDENTITY, t_index'($urandom), t_word'($urandom),
                         t_word'($urandom), t_word'($urandom), t_word'($urandom));
            end else begin
                issue_op(t_opcode'($urandom), t_index'($urandom), t_word'($urandom),
                         t_word'($urandom), t_word'($urandom), t_word'($urandom));
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Result side: random stalls, one long hold-off to back the block up.
    initial begin
        int unsigned burst;
        int          span;
        out_ch.ready = 1'b0;
        span         = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            span++;
            if (span % 256 == 0)
                rx_idle_pct = $urandom_range(0, 3) * 10;
            if (stall_req) begin
                // Hold ready low while the sender keeps offering; the input side
                // must stall once the result register is full.
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge i_clk);
                stall_req = 1'b0;
            end else if (!calm_tail && ($urandom_range(0, 99) < rx_idle_pct)) begin
                burst = $urandom_range(1, 14);
                out_ch.ready <= 1'b0;
                repeat (burst - 1) @(negedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Cycle limit: anything this slow has hung.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/tma_pkg.sv
sv/tma_in_if.sv
sv/tma_out_if.sv
sv/tma_ram.sv
sv/tma_mac_lane.sv
sv/transform_matrix_accumulator.sv
tb/sv/tma_readback_checker.sv
tb/sv/transform_matrix_accumulator_test.sv
